>>> hdl/mfom_pkg.sv
// Package for the field-oriented mecanum mixer: shared widths, bundle types,
// the quarter-wave sine table and the binary-angle sine function. No dependencies.
package mfom_pkg;

  localparam int SINW  = 17;  // signed Q1.15 sine/cosine, 32768 = 1.0
  localparam int PRODW = 34;  // 17 x 17 signed products
  localparam int ROTW  = 18;  // rotated components, signed Q3.14, wide
  localparam int WW    = 19;  // mixed wheel values, signed
  localparam int MAGW  = 18;  // wheel magnitudes
  localparam int QB    = 15;  // quotient bits of the normalizing divide
  localparam int DVW   = 33;  // partial remainder width
  localparam int ONE_Q14 = 16384;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF   = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // One mixed command: four wheels, the largest magnitude and whether
  // the wheels must be divided down by it.
  typedef struct packed {
    logic [3:0][WW-1:0] w;
    logic [MAGW-1:0]    m;
    logic               norm;
  } mix_t;

  typedef struct packed {
    logic [15:0] front_left;
    logic [15:0] front_right;
    logic [15:0] rear_left;
    logic [15:0] rear_right;
  } wheels_t;

  function automatic logic [15:0] sin_tab(input logic [4:0] k);
    logic [15:0] v;
    case (k)
      5'd0:  v = 16'd0;
      5'd1:  v = 16'd3212;
      5'd2:  v = 16'd6393;
      5'd3:  v = 16'd9512;
      5'd4:  v = 16'd12540;
      5'd5:  v = 16'd15447;
      5'd6:  v = 16'd18205;
      5'd7:  v = 16'd20788;
      5'd8:  v = 16'd23170;
      5'd9:  v = 16'd25330;
      5'd10: v = 16'd27246;
      5'd11: v = 16'd28899;
      5'd12: v = 16'd30274;
      5'd13: v = 16'd31357;
      5'd14: v = 16'd32138;
      5'd15: v = 16'd32610;
      5'd16: v = 16'd32768;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // Sine of a binary angle, interpolated inside the quarter wave.
  function automatic logic signed [SINW-1:0] bam_sin(input logic [15:0] a);
    logic [1:0]  quad;
    logic [14:0] p;
    logic [4:0]  idx;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] d;
    logic [25:0] prod;
    logic [16:0] s;
    quad = a[15:14];
    p    = quad[0] ? 15'(15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
    idx  = {1'b0, p[13:10]};
    lo   = sin_tab(idx);
    hi   = sin_tab(5'(idx + 5'd1));
    d    = hi - lo;
    prod = 26'(d) * 26'(p[9:0]);
    if (p[14]) begin
      s = 17'd32768;
    end else begin
      s = {1'b0, lo} + {1'b0, prod[25:10]};
    end
    return quad[1] ? $signed(17'(-s)) : $signed(s);
  endfunction

endpackage

>>> hdl/mfom_fifo.sv
// Small register queue with status struct; used between front and back end
// and as the output buffer. Depends on mfom_pkg.
module mfom_fifo import mfom_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output fifo_stat_t       stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : PW'(wp_r + 1'b1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : PW'(rp_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= CW'(cnt_r + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_r <= CW'(cnt_r - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

>>> hdl/mfom_front.sv
// Front end: heading sine/cosine, field rotation, wheel mix and peak magnitude.
// Four pipeline stages that all hold when the queue cannot take. Depends on mfom_pkg.
module mfom_front import mfom_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [15:0] strafe,
  input  logic [15:0] forward,
  input  logic [15:0] turn,
  input  logic [15:0] heading,
  output logic        in_ready,
  input  logic        q_full,
  output logic        q_push,
  output mix_t        q_data
);

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r;

  logic signed [16:0]      x1_r, ny1_r, r1_r, s1_r, c1_r;
  logic signed [PRODW-1:0] pxc_r, pns_r, pxs_r, pnc_r;
  logic signed [16:0]      r2_r;
  logic signed [WW-1:0]    w3_r [4];
  mix_t                    mix4_r;

  logic signed [PRODW:0]   xa, ya, xadj, yadj;
  logic signed [ROTW-1:0]  xr, yr;
  logic signed [WW-1:0]    wm [4];
  logic [MAGW-1:0]         mag [4];
  logic [MAGW-1:0]         m01, m23, mx;

  assign adv      = !(v4_r && q_full);
  assign in_ready = adv;
  assign q_push   = v4_r && !q_full;
  assign q_data   = mix4_r;

  // Rotation with truncation toward zero on the divide by 32768.
  always_comb begin
    xa   = 35'(pxc_r) - 35'(pns_r);
    ya   = 35'(pxs_r) + 35'(pnc_r);
    xadj = xa + {20'd0, {15{xa[PRODW]}}};
    yadj = ya + {20'd0, {15{ya[PRODW]}}};
    xr   = xadj[32:15];
    yr   = yadj[32:15];
    wm[0] = WW'(xr) + WW'(yr) + WW'(r2_r);
    wm[1] = -WW'(xr) + WW'(yr) - WW'(r2_r);
    wm[2] = -WW'(xr) + WW'(yr) + WW'(r2_r);
    wm[3] = WW'(xr) + WW'(yr) - WW'(r2_r);
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag[k] = w3_r[k][WW-1] ? MAGW'(-w3_r[k]) : MAGW'(w3_r[k]);
    end
    m01 = (mag[1] > mag[0]) ? mag[1] : mag[0];
    m23 = (mag[3] > mag[2]) ? mag[3] : mag[2];
    mx  = (m23 > m01) ? m23 : m01;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r  <= 17'($signed(strafe));
      ny1_r <= -17'($signed(forward));
      r1_r  <= 17'($signed(turn));
      s1_r  <= bam_sin(heading);
      c1_r  <= bam_sin(16'(heading + 16'd16384));
      pxc_r <= x1_r * c1_r;
      pns_r <= ny1_r * s1_r;
      pxs_r <= x1_r * s1_r;
      pnc_r <= ny1_r * c1_r;
      r2_r  <= r1_r;
      for (int k = 0; k < 4; k++) begin
        w3_r[k]       <= wm[k];
        mix4_r.w[k]   <= w3_r[k];
      end
      mix4_r.m    <= mx;
      mix4_r.norm <= (mx > MAGW'(ONE_Q14));
    end
  end

endmodule

>>> hdl/mfom_back.sv
// Back end: normalizing divide (one quotient bit per stage), output scaling and
// saturation; holds whole while a result waits on a full output buffer. Depends on mfom_pkg.
module mfom_back import mfom_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  fifo_stat_t  q_stat,
  input  mix_t        q_data,
  output logic        q_pop,
  input  logic [15:0] max_output,
  input  logic        o_full,
  output logic        o_push,
  output wheels_t     o_data
);

  localparam int PS = QB + 1;  // index of the product stage

  logic adv;
  logic [PS:0] vld_r;

  logic [DVW-1:0]  rem_r  [QB+1][4];
  logic [QB-1:0]   quo_r  [QB+1][4];
  logic [3:0]      sgn_r  [QB+1];
  logic [MAGW-1:0] m_r    [QB+1];
  logic            norm_r [QB+1];
  logic [30:0]     prod_r [4];
  logic [3:0]      sgnp_r;

  logic [MAGW-1:0] mag0 [4];
  logic [16:0]     pm   [4];
  logic [15:0]     res  [4];

  assign adv    = !(vld_r[PS] && o_full);
  assign q_pop  = adv && !q_stat.empty;
  assign o_push = vld_r[PS] && !o_full;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag0[k] = q_data.w[k][WW-1] ? MAGW'(-q_data.w[k]) : MAGW'(q_data.w[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PS-1:0], q_pop};
    end
  end

  // Stage 0: load magnitudes; without normalization the magnitude is the answer.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        rem_r[0][k] <= {1'b0, mag0[k], 14'd0};
        quo_r[0][k] <= q_data.norm ? '0 : mag0[k][QB-1:0];
        sgn_r[0][k] <= q_data.w[k][WW-1];
      end
      m_r[0]    <= q_data.m;
      norm_r[0] <= q_data.norm;
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_div
    localparam int B = QB - s;
    logic [DVW:0] diff [4];
    logic [DVW-1:0] sub;
    always_comb begin
      sub = DVW'(m_r[s-1]) << B;
      for (int k = 0; k < 4; k++) begin
        diff[k] = {1'b0, rem_r[s-1][k]} - {1'b0, sub};
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int k = 0; k < 4; k++) begin
          if (norm_r[s-1] && !diff[k][DVW]) begin
            rem_r[s][k] <= diff[k][DVW-1:0];
            quo_r[s][k] <= quo_r[s-1][k] | (QB'(1) << B);
          end else begin
            rem_r[s][k] <= rem_r[s-1][k];
            quo_r[s][k] <= quo_r[s-1][k];
          end
        end
        sgn_r[s]  <= sgn_r[s-1];
        m_r[s]    <= m_r[s-1];
        norm_r[s] <= norm_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= 31'(quo_r[QB][k]) * 31'(max_output);
      end
      sgnp_r <= sgn_r[QB];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pm[k] = prod_r[k][30:14];
      if (sgnp_r[k]) begin
        res[k] = (pm[k] > 17'd32768) ? 16'h8000 : 16'(-pm[k]);
      end else begin
        res[k] = (pm[k] > 17'd32767) ? 16'h7FFF : pm[k][15:0];
      end
    end
    o_data.front_left  = res[0];
    o_data.front_right = res[1];
    o_data.rear_left   = res[2];
    o_data.rear_right  = res[3];
  end

endmodule

>>> hdl/mecanum_field_oriented_mixer.sv
// Top level of the field-oriented mecanum mixer: front end, command queue,
// back end and output buffer. Depends on mfom_pkg, mfom_fifo, mfom_front, mfom_back.
//
//   Channel   Ports                                      Transfer when
//   input     in_strafe/forward/turn/heading, push,full  push && !full
//   result    out_front_left/.../rear_right, empty,pop    pop && !empty
//   config    cfg_we, cfg_wdata (max_output)             cfg_we
//
// One command is taken per cycle while full is low. A command passes the front end,
// the queue and the back end (one load, fifteen divide steps, one multiply)
// before it reaches the output buffer; the fifteen-step divide pipeline sets most
// of that latency. Reset is synchronous and empties every stage and queue and
// sets max_output to 1.0. A full output buffer holds the back end; a full queue
// holds the front end and raises full.
module mecanum_field_oriented_mixer import mfom_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int OUT_DEPTH   = OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_strafe,
  input  logic [15:0] in_forward,
  input  logic [15:0] in_turn,
  input  logic [15:0] in_heading,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_front_left,
  output logic [15:0] out_front_right,
  output logic [15:0] out_rear_left,
  output logic [15:0] out_rear_right,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] max_output_r;
  logic        front_ready;
  logic        q_push, q_pop, o_push;
  mix_t        q_wdata, q_rdata;
  fifo_stat_t  q_stat, o_stat;
  wheels_t     o_wdata, o_rdata;

  // The user must change the scale register only while the datapath is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_output_r <= 16'd32768;
    end else if (cfg_we) begin
      max_output_r <= cfg_wdata;
    end
  end

  assign full = !front_ready;

  mfom_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (push),
    .strafe   (in_strafe),
    .forward  (in_forward),
    .turn     (in_turn),
    .heading  (in_heading),
    .in_ready (front_ready),
    .q_full   (q_stat.full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  // The queue decouples the rotate/mix front from the divide/scale back.
  mfom_fifo #(.WIDTH($bits(mix_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wdata),
    .pop     (q_pop),
    .rd_data (q_rdata),
    .stat    (q_stat)
  );

  mfom_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .max_output (max_output_r),
    .o_full     (o_stat.full),
    .o_push     (o_push),
    .o_data     (o_wdata)
  );

  // Output buffer: results wait here until popped; when it is full the back end holds.
  mfom_fifo #(.WIDTH($bits(wheels_t)), .DEPTH(OUT_DEPTH)) u_outbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (o_push),
    .wr_data (o_wdata),
    .pop     (pop),
    .rd_data (o_rdata),
    .stat    (o_stat)
  );

  assign empty           = o_stat.empty;
  assign out_front_left  = o_rdata.front_left;
  assign out_front_right = o_rdata.front_right;
  assign out_rear_left   = o_rdata.rear_left;
  assign out_rear_right  = o_rdata.rear_right;

  // The front end must never write a full queue.
  a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_stat.full)) else $error("queue written while full");

  // The back end must never take from an empty queue.
  a_q_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_stat.empty)) else $error("queue read while empty");

  // The back end must never write a full output buffer.
  a_o_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(o_push && o_stat.full)) else $error("output buffer written while full");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result pending after reset");

endmodule
